// ===== sv/numext_pkg.sv =====
// numext_pkg: types and constants for the decimal number extractor
// transfer payload structs, character codes, capacity and fraction digit weights
// no dependencies
package numext_pkg;

  localparam int MAX_NUMBERS = 16;
  localparam int COUNT_W     = $clog2(MAX_NUMBERS + 1);
  localparam int INDEX_W     = 4;
  localparam int INT_W       = 15;
  localparam int WPOS_W      = 4;

  localparam logic [INT_W-1:0]  INT_MAX_PART = 15'd32767;
  localparam logic [WPOS_W-1:0] WPOS_LAST    = 4'd9;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } char_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [3:0]         number_index;
    logic               has_number;
    logic               last;
    logic [4:0]         total_count;
    logic               dropped;
  } num_item_t;

  // weight of the next fraction digit, 0.32 fixed point; each step is (w+5)/10
  function automatic logic [31:0] digit_weight(input logic [WPOS_W-1:0] pos);
    logic [31:0] w;
    unique case (pos)
      4'd0:    w = 32'd429496730;
      4'd1:    w = 32'd42949673;
      4'd2:    w = 32'd4294967;
      4'd3:    w = 32'd429497;
      4'd4:    w = 32'd42950;
      4'd5:    w = 32'd4295;
      4'd6:    w = 32'd430;
      4'd7:    w = 32'd43;
      4'd8:    w = 32'd4;
      default: w = 32'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== sv/number_extractor_from_text.sv =====
// number_extractor_from_text: top level of the decimal number extractor
// input register, tokenizer logic and result register
// depends on numext_pkg
//
// Takes one text character per transfer and emits signed Q16.16 numbers found
// in it. Digits form an integer part (saturating at 32767), a point after
// digits starts a fraction, and each '-' toggles the sign of the next number.
// Any other character ends a pending number; the end-of-text transfer always
// yields one result flagged last, with the final count and the dropped flag,
// and returns the block to its reset state. Up to 16 numbers per text are
// kept; later ones are dropped and flagged. The block accepts one character
// every cycle unless the output stalls; a character is held in the input
// register and its result in the result register, the whole per-character
// update being combinational logic around the tokenizer state.
module number_extractor_from_text
  import numext_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  char_item_t char_item,
  output logic       num_valid,
  input  logic       num_stall,
  output num_item_t  num_item
);

  // input register
  logic       hold_valid;
  char_item_t hold;

  // tokenizer state
  logic [INT_W-1:0]   integer_part, integer_part_next;
  logic [31:0]        fraction_part, fraction_part_next;
  logic [WPOS_W-1:0]  weight_pos, weight_pos_next;
  logic               in_number, in_number_next;
  logic               in_fraction, in_fraction_next;
  logic               sign_pending, sign_pending_next;
  logic [COUNT_W-1:0] kept_count, kept_count_next;
  logic               overflow_seen, overflow_seen_next;

  logic      result_fire;
  num_item_t result_next;

  logic out_free;
  logic consume;

  assign out_free   = !num_valid || !num_stall;
  assign consume    = hold_valid && out_free;
  assign char_stall = hold_valid && !out_free;

  // datapath pieces
  logic               is_digit;
  logic [3:0]         digit;
  logic [35:0]        frac_prod;
  logic [36:0]        frac_sum;
  logic [18:0]        int_mul;
  logic [16:0]        frac_round;
  logic [31:0]        magnitude;
  logic [31:0]        q16;
  logic               can_keep;
  logic [COUNT_W-1:0] count_inc;

  always_comb begin
    is_digit   = (hold.char_code >= CHAR_ZERO) && (hold.char_code <= CHAR_NINE);
    digit      = 4'(hold.char_code - CHAR_ZERO);
    frac_prod  = 36'(digit) * 36'(digit_weight(weight_pos));
    frac_sum   = 37'(fraction_part) + 37'(frac_prod);
    int_mul    = 19'(integer_part) * 19'd10 + 19'(digit);
    frac_round = 17'((33'(fraction_part) + 33'h8000) >> 16);
    magnitude  = {1'b0, integer_part, 16'h0} + 32'(frac_round);
    if (sign_pending) begin
      q16 = 32'd0 - magnitude;
    end else if (magnitude > 32'h7FFF_FFFF) begin
      q16 = 32'h7FFF_FFFF;
    end else begin
      q16 = magnitude;
    end
    can_keep  = in_number && (kept_count < COUNT_W'(MAX_NUMBERS));
    count_inc = kept_count + COUNT_W'(1);
  end

  always_comb begin
    integer_part_next  = integer_part;
    fraction_part_next = fraction_part;
    weight_pos_next    = weight_pos;
    in_number_next     = in_number;
    in_fraction_next   = in_fraction;
    sign_pending_next  = sign_pending;
    kept_count_next    = kept_count;
    overflow_seen_next = overflow_seen;
    result_fire        = 1'b0;
    result_next        = '0;

    if (hold.end_of_text) begin
      result_fire              = 1'b1;
      result_next.last         = 1'b1;
      result_next.has_number   = can_keep;
      result_next.value        = can_keep ? q16 : 32'sd0;
      result_next.number_index = can_keep ? INDEX_W'(kept_count) : '0;
      result_next.total_count  = 5'(can_keep ? count_inc : kept_count);
      result_next.dropped      = overflow_seen || (in_number && !can_keep);
      integer_part_next  = '0;
      fraction_part_next = '0;
      weight_pos_next    = '0;
      in_number_next     = 1'b0;
      in_fraction_next   = 1'b0;
      sign_pending_next  = 1'b0;
      kept_count_next    = '0;
      overflow_seen_next = 1'b0;
    end else if (is_digit) begin
      in_number_next = 1'b1;
      if (!in_number) begin
        integer_part_next  = INT_W'(digit);
        fraction_part_next = '0;
        in_fraction_next   = 1'b0;
        weight_pos_next    = '0;
      end else if (in_fraction) begin
        fraction_part_next = (frac_sum[36:32] != 5'd0) ? 32'hFFFF_FFFF : frac_sum[31:0];
        if (weight_pos != WPOS_LAST) begin
          weight_pos_next = weight_pos + WPOS_W'(1);
        end
      end else begin
        integer_part_next = (int_mul > 19'(INT_MAX_PART)) ? INT_MAX_PART
                                                          : INT_W'(int_mul);
      end
    end else if ((hold.char_code == CHAR_POINT) && in_number) begin
      in_fraction_next = 1'b1;
    end else begin
      if (in_number) begin
        in_number_next    = 1'b0;
        in_fraction_next  = 1'b0;
        sign_pending_next = 1'b0;
        if (can_keep) begin
          kept_count_next          = count_inc;
          result_fire              = 1'b1;
          result_next.has_number   = 1'b1;
          result_next.value        = q16;
          result_next.number_index = INDEX_W'(kept_count);
          result_next.total_count  = 5'(count_inc);
          result_next.dropped      = overflow_seen;
        end else begin
          overflow_seen_next = 1'b1;
        end
      end
      if (hold.char_code == CHAR_MINUS) begin
        sign_pending_next = in_number ? 1'b1 : !sign_pending;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid    <= 1'b0;
      num_valid     <= 1'b0;
      integer_part  <= '0;
      fraction_part <= '0;
      weight_pos    <= '0;
      in_number     <= 1'b0;
      in_fraction   <= 1'b0;
      sign_pending  <= 1'b0;
      kept_count    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (char_valid && !char_stall) begin
        hold_valid <= 1'b1;
        hold       <= char_item;
      end else if (consume) begin
        hold_valid <= 1'b0;
      end
      if (consume) begin
        integer_part  <= integer_part_next;
        fraction_part <= fraction_part_next;
        weight_pos    <= weight_pos_next;
        in_number     <= in_number_next;
        in_fraction   <= in_fraction_next;
        sign_pending  <= sign_pending_next;
        kept_count    <= kept_count_next;
        overflow_seen <= overflow_seen_next;
      end
      if (out_free) begin
        num_valid <= consume && result_fire;
        if (consume && result_fire) begin
          num_item <= result_next;
        end
      end
    end
  end

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for number_extractor_from_text
// predicts each Q16.16 number from the character stream and checks every transfer
// depends on numext_pkg and the number_extractor_from_text rtl
module tb_top;
  import numext_pkg::*;

  localparam logic [31:0] WEIGHT_FIRST = 32'd429496730;
  localparam int PHASE_ITEMS = 275;
  localparam int HOLD_LEN = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic char_valid = 1'b0;
  logic char_stall;
  char_item_t char_item = '0;
  logic num_valid;
  logic num_stall = 1'b0;
  num_item_t num_item;

  number_extractor_from_text dut (
    .clk(clk),
    .rst(rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_item(char_item),
    .num_valid(num_valid),
    .num_stall(num_stall),
    .num_item(num_item)
  );

  always #10 clk = ~clk;

  char_item_t pending_chars[$];
  num_item_t expected_nums[$];
  int pushed_items = 0;
  int accepted_items = 0;
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int sender_idle[4] = '{0, 66, 0, 11};
  int receiver_stall[4] = '{0, 0, 66, 11};

  // tokenizer state
  logic [14:0] int_acc;
  logic [31:0] frac_acc;
  logic [31:0] frac_weight;
  logic digits_open;
  logic after_point;
  logic minus_pending;
  logic [4:0] numbers_kept;
  logic capacity_hit;

  function automatic void clear_tokenizer();
    int_acc = '0;
    frac_acc = '0;
    frac_weight = WEIGHT_FIRST;
    digits_open = 1'b0;
    after_point = 1'b0;
    minus_pending = 1'b0;
    numbers_kept = '0;
    capacity_hit = 1'b0;
  endfunction

  function automatic logic [31:0] fixed_value();
    logic [32:0] frac_rnd;
    logic [32:0] mag;
    frac_rnd = ({1'b0, frac_acc} + 33'h8000) >> 16;
    mag = {2'b00, int_acc, 16'h0000} + frac_rnd;
    if (!minus_pending) begin
      return (mag > 33'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
    end
    return 32'd0 - mag[31:0];
  endfunction

  function automatic bit close_number(output logic [31:0] v, output logic [3:0] idx);
    bit kept;
    kept = 1'b0;
    v = '0;
    idx = '0;
    if (numbers_kept < MAX_NUMBERS) begin
      v = fixed_value();
      idx = numbers_kept[3:0];
      numbers_kept = numbers_kept + 5'd1;
      kept = 1'b1;
    end else begin
      capacity_hit = 1'b1;
    end
    minus_pending = 1'b0;
    digits_open = 1'b0;
    after_point = 1'b0;
    return kept;
  endfunction

  function automatic bit tokenize_char(input char_item_t it, output num_item_t res);
    logic [31:0] v;
    logic [3:0] idx;
    logic [3:0] d;
    logic [19:0] int_next;
    logic [36:0] frac_next;
    bit kept;
    res = '0;
    v = '0;
    idx = '0;
    kept = 1'b0;
    if (it.end_of_text) begin
      if (digits_open) kept = close_number(v, idx);
      res.value = v;
      res.number_index = idx;
      res.has_number = kept;
      res.last = 1'b1;
      res.total_count = numbers_kept;
      res.dropped = capacity_hit;
      clear_tokenizer();
      return 1'b1;
    end
    if (it.char_code >= CHAR_ZERO && it.char_code <= CHAR_NINE) begin
      d = 4'(it.char_code - CHAR_ZERO);
      if (!digits_open) begin
        int_acc = 15'(d);
        frac_acc = '0;
        after_point = 1'b0;
        frac_weight = WEIGHT_FIRST;
      end else if (after_point) begin
        frac_next = 37'(frac_acc) + 37'(d) * 37'(frac_weight);
        frac_acc = (frac_next > 37'hFFFFFFFF) ? 32'hFFFFFFFF : frac_next[31:0];
        frac_weight = 32'((33'(frac_weight) + 33'd5) / 33'd10);
      end else begin
        int_next = 20'(int_acc) * 20'd10 + 20'(d);
        int_acc = (int_next > 20'(INT_MAX_PART)) ? INT_MAX_PART : int_next[14:0];
      end
      digits_open = 1'b1;
      return 1'b0;
    end
    if (it.char_code == CHAR_POINT && digits_open) begin
      after_point = 1'b1;
      return 1'b0;
    end
    if (digits_open) kept = close_number(v, idx);
    if (it.char_code == CHAR_MINUS) minus_pending = !minus_pending;
    if (kept) begin
      res.value = v;
      res.number_index = idx;
      res.has_number = 1'b1;
      res.last = 1'b0;
      res.total_count = numbers_kept;
      res.dropped = capacity_hit;
    end
    return kept;
  endfunction

  function automatic void report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch expected %h actual %h", $time, field, want, got);
    errors++;
  endfunction

  // sender side
  always @(posedge clk) begin : drive_chars
    num_item_t emitted_num;
    if (rst) begin
      char_valid <= 1'b0;
      clear_tokenizer();
    end else begin
      if (char_valid && !char_stall) begin
        accepted_items <= accepted_items + 1;
        if (tokenize_char(char_item, emitted_num)) expected_nums.push_back(emitted_num);
      end
      if (!char_valid || !char_stall) begin
        if (pending_chars.size() > 0 && $urandom_range(99) >= idle_pct) begin
          char_valid <= 1'b1;
          char_item <= pending_chars.pop_front();
        end else begin
          char_valid <= 1'b0;
        end
      end
    end
  end

  // receiver side
  always @(posedge clk) begin : watch_nums
    num_item_t want;
    if (rst) begin
      num_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (num_valid && !num_stall) begin
        if (expected_nums.size() == 0) begin
          $display("%0t: unexpected transfer, actual %p", $time, num_item);
          errors++;
        end else begin
          want = expected_nums.pop_front();
          if (num_item.value !== want.value)
            report_mismatch("value", want.value, num_item.value);
          if (num_item.number_index !== want.number_index)
            report_mismatch("number_index", 32'(want.number_index), 32'(num_item.number_index));
          if (num_item.has_number !== want.has_number)
            report_mismatch("has_number", 32'(want.has_number), 32'(num_item.has_number));
          if (num_item.last !== want.last)
            report_mismatch("last", 32'(want.last), 32'(num_item.last));
          if (num_item.total_count !== want.total_count)
            report_mismatch("total_count", 32'(want.total_count), 32'(num_item.total_count));
          if (num_item.dropped !== want.dropped)
            report_mismatch("dropped", 32'(want.dropped), 32'(num_item.dropped));
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_LEN;
        num_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        num_stall <= 1'b1;
      end else begin
        num_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (num_valid && !num_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_char(input logic [7:0] c, input logic eot);
    char_item_t it;
    it.char_code = c;
    it.end_of_text = eot;
    pending_chars.push_back(it);
    pushed_items++;
  endtask

  task automatic push_string(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0);
  endtask

  function automatic logic [7:0] pick_separator();
    unique case ($urandom_range(5))
      0: return 8'h20;
      1: return 8'h2C;
      2: return CHAR_MINUS;
      3: return CHAR_POINT;
      4: return 8'h61 + 8'($urandom_range(25));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic push_digits(input int count, input bit all_nines);
    for (int j = 0; j < count; j++)
      push_char(all_nines ? CHAR_NINE : CHAR_ZERO + 8'($urandom_range(9)), 1'b0);
  endtask

  task automatic add_text();
    int n_numbers;
    int nd;
    bit all_nines;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 10)) push_char(8'($urandom_range(255)), 1'b0);
    end else begin
      n_numbers = ($urandom_range(9) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 6);
      for (int k = 0; k < n_numbers; k++) begin
        if ($urandom_range(7) == 0) push_char(CHAR_POINT, 1'b0);
        if ($urandom_range(3) == 0) push_char(CHAR_MINUS, 1'b0);
        if ($urandom_range(7) == 0) push_char(CHAR_MINUS, 1'b0);
        all_nines = ($urandom_range(7) == 0);
        nd = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        push_digits(nd, all_nines);
        if ($urandom_range(1)) begin
          push_char(CHAR_POINT, 1'b0);
          nd = ($urandom_range(5) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
          push_digits(nd, all_nines);
          if ($urandom_range(5) == 0) push_char(CHAR_POINT, 1'b0);
        end
        if (!(k == n_numbers - 1 && $urandom_range(2) == 0)) push_char(pick_separator(), 1'b0);
        if ($urandom_range(11) == 0) push_char(8'($urandom_range(255)), 1'b0);
      end
    end
    push_char(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic wait_drained();
    while (!(accepted_items == pushed_items && expected_nums.size() == 0)) @(posedge clk);
  endtask

  initial begin
    int start;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // directed: saturation, deep fraction, minus after digits, bare marker
    push_string("-99999.9999999999.");
    push_char(8'hFF, 1'b1);
    push_string("5-3/");
    push_char(8'h00, 1'b1);
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct <= sender_idle[ph];
      stall_pct <= receiver_stall[ph];
      @(posedge clk);
      start = pushed_items;
      while (pushed_items - start < PHASE_ITEMS) add_text();
      if (ph == 0) begin
        while (accepted_items < start + 30) @(posedge clk);
        hold_req <= hold_req + 1;
      end
      wait_drained();
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_nums.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
